[hdl/ket_pkg.sv]
package ket_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int CountW = 7;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_STRIKE = 2'd2,
    ACT_LOOKUP = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_DONE       = 3'd0,
    ST_DUP        = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_MISSING    = 3'd3,
    ST_FULL       = 3'd4,
    ST_STRUCK_OUT = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]   action;
    logic signed [31:0] entry_key;
    logic [7:0]   data_high;
    logic [7:0]   data_low;
    logic         solar_flag;
    logic         enable_flag;
  } cmd_t;

  typedef struct packed {
    logic [2:0]   status;
    logic [7:0]   found_high;
    logic [7:0]   found_low;
    logic signed [31:0] found_key;
    logic [CountW-1:0] entry_count;
  } rsp_t;

endpackage

[hdl/ket_front.sv]
// Two-entry command queue: accepts commands and presents the oldest one to the back end.
module ket_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  ket_pkg::cmd_t cmd,
  output logic          cmd_valid,
  output ket_pkg::cmd_t cmd_head,
  input  logic          cmd_take
);
  import ket_pkg::*;

  cmd_t       q [2];
  logic [1:0] fill;
  logic       rd_ptr;
  logic       wr_ptr;

  assign full      = fill[1];
  assign cmd_valid = (fill != 2'd0);
  assign cmd_head  = q[rd_ptr];

  // Store incoming command
  always_ff @(posedge clk) begin
    if (push && !full) q[wr_ptr] <= cmd;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (cmd_take) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'((push && !full) ? 1 : 0) - 2'(cmd_take ? 1 : 0);
    end
  end
endmodule

[hdl/ket_back.sv]
// Table engine: compare all slots, pick slot, update, then emit a result.
module ket_back #(
  parameter int TABLE_ENTRIES = ket_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  ket_pkg::cmd_t cmd_head,
  output logic          cmd_take,
  output logic          empty,
  input  logic          pop,
  output ket_pkg::rsp_t rsp
);
  import ket_pkg::*;

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int TotW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MATCH = 4'b0010,
    S_EXEC  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state;
  cmd_t   cur;

  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [31:0] slot_key    [TABLE_ENTRIES];
  logic [7:0]  slot_high   [TABLE_ENTRIES];
  logic [7:0]  slot_low    [TABLE_ENTRIES];
  logic        slot_solar  [TABLE_ENTRIES];
  logic        slot_enable [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] slot_struck;
  logic [TotW-1:0] valid_total;

  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic [IdxW-1:0] hit_idx, free_idx;
  logic hit_any, free_any;
  logic [IdxW-1:0] hit_idx_next, free_idx_next;
  logic hit_any_next, free_any_next;

  logic [2:0]  rsp_status;
  logic [7:0]  rsp_high;
  logic [7:0]  rsp_low;
  logic [31:0] rsp_key;

  // Parallel key compare in every slot
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++)
      hit_vec[i] = slot_valid[i] && (slot_key[i] == cur.entry_key);
  end

  // Encode hit slot and lowest free slot (keys distinct: at most one hit)
  always_comb begin
    hit_idx_next  = '0;
    free_idx_next = '0;
    hit_any_next  = |hit_vec;
    free_any_next = ~&slot_valid;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i])     hit_idx_next  = IdxW'(i);
      if (!slot_valid[i]) free_idx_next = IdxW'(i);
    end
  end

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign empty    = (state != S_OUT);

  // Sequence one command through match, update and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_valid  <= '0;
      valid_total <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (cmd_valid) state <= S_MATCH;
        S_MATCH: state <= S_EXEC;
        S_EXEC: begin
          state <= S_OUT;
          if (cur.action == ACT_ADD) begin
            if (!hit_any && free_any) begin
              slot_valid[free_idx] <= 1'b1;
              valid_total <= valid_total + TotW'(1);
            end
          end else if (valid_total != '0 && hit_any) begin
            if (cur.action == ACT_DELETE ||
                (cur.action == ACT_STRIKE && slot_struck[hit_idx])) begin
              slot_valid[hit_idx] <= 1'b0;
              valid_total <= valid_total - TotW'(1);
            end
          end
        end
        S_OUT: if (pop) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the command, match results and slot payload
  always_ff @(posedge clk) begin
    if (cmd_take) cur <= cmd_head;
    if (state == S_MATCH) begin
      hit_idx  <= hit_idx_next;
      hit_any  <= hit_any_next;
      free_idx <= free_idx_next;
      free_any <= free_any_next;
    end
    if (state == S_EXEC) begin
      rsp_status <= ST_DONE;
      rsp_high   <= '0;
      rsp_low    <= '0;
      rsp_key    <= '0;
      if (cur.action == ACT_ADD) begin
        if (hit_any) rsp_status <= ST_DUP;
        else if (!free_any) rsp_status <= ST_FULL;
        else begin
          slot_key[free_idx]    <= cur.entry_key;
          slot_high[free_idx]   <= cur.data_high;
          slot_low[free_idx]    <= cur.data_low;
          slot_solar[free_idx]  <= cur.solar_flag;
          slot_enable[free_idx] <= cur.enable_flag;
          slot_struck[free_idx] <= 1'b0;
        end
      end else if (valid_total == '0) begin
        rsp_status <= ST_EMPTY;
      end else if (!hit_any) begin
        rsp_status <= ST_MISSING;
      end else if (cur.action == ACT_STRIKE) begin
        if (slot_struck[hit_idx]) rsp_status <= ST_STRUCK_OUT;
        else slot_struck[hit_idx] <= 1'b1;
      end else if (cur.action == ACT_LOOKUP) begin
        rsp_high <= slot_high[hit_idx];
        rsp_low  <= slot_low[hit_idx];
        rsp_key  <= slot_key[hit_idx];
      end
    end
  end

  // Pack the result; the count follows the table total
  assign rsp = {rsp_status, rsp_high, rsp_low, rsp_key, CountW'(valid_total)};
endmodule

[hdl/keyed_entry_table_with_strikes_core.sv]
// From an accepted push to the result shown when idle, a command passes take, match and update.
// The back end handles one command at a time: its sequencer runs match and update in separate
// states and takes no new command until the result is popped.
// A two-deep front queue takes commands while the back end works.
// Reset (synchronous, rst high) empties the queue and clears every valid bit.
module keyed_entry_table_with_strikes_core #(
  parameter int TABLE_ENTRIES = ket_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  ket_pkg::cmd_t cmd,
  output logic          empty,
  input  logic          pop,
  output ket_pkg::rsp_t rsp
);
  import ket_pkg::*;

  logic cmd_valid, cmd_take;
  cmd_t cmd_head;

  ket_front u_front (
    .clk, .rst, .push, .full, .cmd,
    .cmd_valid, .cmd_head, .cmd_take
  );

  ket_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst, .cmd_valid, .cmd_head, .cmd_take,
    .empty, .pop, .rsp
  );

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp.entry_count <= CountW'(TABLE_ENTRIES) || TABLE_ENTRIES > 127)
    else $error("entry count beyond table size");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(rsp)))
    else $error("result changed while waiting");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !cmd_take)
    else $error("command taken while result pending");
`endif
endmodule

[tb/sv/keyed_entry_table_with_strikes_core_checker.sv]
module keyed_entry_table_with_strikes_core_checker
  import ket_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic full,
  input  cmd_t cmd,
  input  logic empty,
  input  logic pop,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending,
  output int   rsp_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // mirror of the table
  logic        tbl_valid [TABLE_ENTRIES];
  logic [31:0] tbl_key   [TABLE_ENTRIES];
  logic [7:0]  tbl_high  [TABLE_ENTRIES];
  logic [7:0]  tbl_low   [TABLE_ENTRIES];
  logic        tbl_struck[TABLE_ENTRIES];
  int          tbl_total;
  rsp_t        rsp_expected[$];

  function automatic int find_key(logic [31:0] k);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (!tbl_valid[i]) return i;
    return -1;
  endfunction

  // apply one command to the mirror and build its response
  function automatic rsp_t apply_cmd(cmd_t c);
    rsp_t r;
    int s;
    r = '0;
    r.status = ST_DONE;
    if (c.action == ACT_ADD) begin
      if (find_key(c.entry_key) >= 0) begin
        r.status = ST_DUP;
      end else begin
        s = find_free();
        if (s < 0) begin
          r.status = ST_FULL;
        end else begin
          tbl_valid[s] = 1'b1;
          tbl_key[s] = c.entry_key;
          tbl_high[s] = c.data_high;
          tbl_low[s] = c.data_low;
          tbl_struck[s] = 1'b0;
          tbl_total++;
        end
      end
    end else if (tbl_total == 0) begin
      r.status = ST_EMPTY;
    end else begin
      s = find_key(c.entry_key);
      if (s < 0) begin
        r.status = ST_MISSING;
      end else if (c.action == ACT_DELETE) begin
        tbl_valid[s] = 1'b0;
        tbl_total--;
      end else if (c.action == ACT_STRIKE) begin
        if (tbl_struck[s]) begin
          tbl_valid[s] = 1'b0;
          tbl_total--;
          r.status = ST_STRUCK_OUT;
        end else begin
          tbl_struck[s] = 1'b1;
        end
      end else begin
        r.found_high = tbl_high[s];
        r.found_low = tbl_low[s];
        r.found_key = tbl_key[s];
      end
    end
    r.entry_count = tbl_total[CountW-1:0];
    return r;
  endfunction

  // predict on accepted commands, compare on accepted responses
  always @(posedge clk) begin
    rsp_t exp_r;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
      tbl_total = 0;
      rsp_expected.delete();
      fail_count = 0;
      rsp_seen = 0;
      pending = 0;
    end else begin
      if (pop && !empty) begin
        rsp_seen++;
        if (rsp_expected.size() == 0) begin
          $display("%0t: unexpected response %p", $time, rsp);
          fail_count++;
        end else begin
          exp_r = rsp_expected.pop_front();
          if (rsp.status !== exp_r.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp_r.status, rsp.status);
            fail_count++;
          end
          if (rsp.found_high !== exp_r.found_high) begin
            $display("%0t: found_high exp %h got %h", $time, exp_r.found_high,
                     rsp.found_high);
            fail_count++;
          end
          if (rsp.found_low !== exp_r.found_low) begin
            $display("%0t: found_low exp %h got %h", $time, exp_r.found_low,
                     rsp.found_low);
            fail_count++;
          end
          if (rsp.found_key !== exp_r.found_key) begin
            $display("%0t: found_key exp %h got %h", $time, exp_r.found_key,
                     rsp.found_key);
            fail_count++;
          end
          if (rsp.entry_count !== exp_r.entry_count) begin
            $display("%0t: entry_count exp %0d got %0d", $time, exp_r.entry_count,
                     rsp.entry_count);
            fail_count++;
          end
        end
      end
      if (push && !full) rsp_expected.push_back(apply_cmd(cmd));
      pending = rsp_expected.size();
    end
  end
endmodule

[tb/sv/keyed_entry_table_with_strikes_core_tb.sv]
module keyed_entry_table_with_strikes_core_tb;
  import ket_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  cmd_t cmd = '0;
  rsp_t rsp;
  int   fail_count, pending, rsp_seen;
  int   idle_cycles = 0;
  bit   hold_off = 1'b0;
  logic [31:0] key_pool[8];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  keyed_entry_table_with_strikes_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd),
    .empty(empty), .pop(pop), .rsp(rsp)
  );

  keyed_entry_table_with_strikes_core_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd),
    .empty(empty), .pop(pop), .rsp(rsp),
    .fail_count(fail_count), .pending(pending), .rsp_seen(rsp_seen)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // offer one transaction and hold it until accepted
  task automatic send_cmd(action_t a, logic [31:0] k);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk);
    end
    cmd.action <= a;
    cmd.entry_key <= k;
    cmd.data_high <= 8'($urandom_range(0, 255));
    cmd.data_low <= 8'($urandom_range(0, 255));
    cmd.solar_flag <= 1'($urandom_range(0, 1));
    cmd.enable_flag <= 1'($urandom_range(0, 1));
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7fff_fffc + $urandom_range(0, 3);
      default: return key_pool[$urandom_range(0, 7)];
    endcase
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        pop <= 1'b0;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int n;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0;
    key_pool[3] = 32'hffff_ffff;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, duplicate, strike twice, absent key
    send_cmd(ACT_DELETE, 32'h0);
    send_cmd(ACT_STRIKE, 32'h1);
    send_cmd(ACT_LOOKUP, 32'h2);
    send_cmd(ACT_ADD, 32'h8000_0000);
    send_cmd(ACT_ADD, 32'h7fff_ffff);
    send_cmd(ACT_ADD, 32'hffff_ffff);
    send_cmd(ACT_ADD, 32'h8000_0000);
    send_cmd(ACT_LOOKUP, 32'h8000_0000);
    send_cmd(ACT_LOOKUP, 32'h7fff_ffff);
    send_cmd(ACT_LOOKUP, 32'h1234_5678);
    send_cmd(ACT_STRIKE, 32'hffff_ffff);
    send_cmd(ACT_LOOKUP, 32'hffff_ffff);
    send_cmd(ACT_STRIKE, 32'hffff_ffff);
    send_cmd(ACT_DELETE, 32'hffff_ffff);
    send_cmd(ACT_DELETE, 32'h7fff_ffff);
    send_cmd(ACT_STRIKE, 32'h5555_5555);

    // fill the table while the receiver holds off, then hit full and duplicate
    hold_off = 1'b1;
    for (int i = 0; i < 64; i++) send_cmd(ACT_ADD, 32'h100 + i);
    send_cmd(ACT_ADD, 32'h0abc_def0);
    send_cmd(ACT_ADD, 32'h100);
    for (int i = 0; i < 64; i++) send_cmd(ACT_DELETE, 32'h100 + i);

    // random: mostly pooled keys so hits are common; fill phases now and then
    n = 0;
    while (n < 1300) begin
      if ($urandom_range(0, 199) == 0) begin
        for (int i = 0; i < 66; i++) send_cmd(ACT_ADD, $urandom());
        n += 66;
      end else begin
        send_cmd(action_t'($urandom_range(0, 3)), pick_key());
        n++;
      end
    end

    // drop the request after the last transaction
    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d responses: add, delete, strike, lookup, full table,", rsp_seen);
    $display("duplicates, empty-table and absent-key cases with random stalls.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[keyed_entry_table_with_strikes_core.f]
hdl/ket_pkg.sv
hdl/ket_front.sv
hdl/ket_back.sv
hdl/keyed_entry_table_with_strikes_core.sv
tb/sv/keyed_entry_table_with_strikes_core_checker.sv
tb/sv/keyed_entry_table_with_strikes_core_tb.sv
